// ===== rtl/mask_iou_depth_error_accumulator_defines.svh =====
// Assertion macros shared by the RTL files.
// Each one expects clk and rst_n in the enclosing module.
`ifndef MASK_IOU_DEPTH_ERROR_ACCUMULATOR_DEFINES_SVH
`define MASK_IOU_DEPTH_ERROR_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication
`define MIDE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define MIDE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mide_pkg.sv =====
`timescale 1ns / 1ps

package mide_pkg;

    // Field widths
    localparam int MASK_W     = 8;
    localparam int DEPTH_BITS = 20;
    localparam int CNT_W      = 17;
    localparam int SUM_W      = 36;
    localparam int COST_W     = 17;
    localparam int MEAN_W     = 20;
    localparam int FRAC_Q16   = 16;

    // Divider sizing: full-width dividend, count-width divisor
    localparam int DIV_STEPS = SUM_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Constants
    localparam logic [CNT_W-1:0]      CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [SUM_W-1:0]      SUM_MAX  = {SUM_W{1'b1}};
    localparam logic [MEAN_W-1:0]     MEAN_MAX = {MEAN_W{1'b1}};
    localparam logic [DEPTH_BITS-1:0] BG_DEPTH = DEPTH_BITS'(262144);
    localparam logic [COST_W-1:0]     ONE_Q16  = COST_W'(65536);
    localparam logic [MEAN_W-1:0]     ONE_Q8   = MEAN_W'(256);

    // Controller states
    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_COST_GO,
        ST_COST_WAIT,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_LOAD
    } mide_state_t;

    // Controller to datapath
    typedef struct packed {
        logic acc_en;     // pixel request taken this cycle
        logic div_start;  // launch a division
        logic div_mean;   // operands: 1 = mean depth, 0 = IoU cost
        logic cap_cost;   // latch the cost quotient
        logic load;       // fill output register and clear accumulators
    } mide_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic div_busy;
        logic div_done;
    } mide_stat_t;

endpackage

// ===== rtl/mide_pix_if.sv =====
`timescale 1ns / 1ps

interface mide_pix_if import mide_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [MASK_W-1:0]     meas_mask;
    logic [MASK_W-1:0]     rend_mask;
    logic [DEPTH_BITS-1:0] meas_depth;
    logic [DEPTH_BITS-1:0] rend_depth;
    logic                  last_pixel;

    modport source (
        output valid, meas_mask, rend_mask, meas_depth, rend_depth, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, meas_mask, rend_mask, meas_depth, rend_depth, last_pixel,
        output ready
    );
endinterface

// ===== rtl/mide_res_if.sv =====
`timescale 1ns / 1ps

interface mide_res_if import mide_pkg::*;;
    logic              valid;
    logic              ready;
    logic [COST_W-1:0] iou_cost;
    logic [MEAN_W-1:0] mean_depth_error;
    logic [CNT_W-1:0]  intersection_count;
    logic [CNT_W-1:0]  union_count;
    logic [CNT_W-1:0]  depth_pixel_count;
    logic [SUM_W-1:0]  depth_error_sum;
    logic              union_empty;

    modport source (
        output valid, iou_cost, mean_depth_error, intersection_count, union_count,
               depth_pixel_count, depth_error_sum, union_empty,
        input  ready
    );

    modport sink (
        input  valid, iou_cost, mean_depth_error, intersection_count, union_count,
               depth_pixel_count, depth_error_sum, union_empty,
        output ready
    );
endinterface

// ===== rtl/mask_iou_depth_error_accumulator.sv =====
`timescale 1ns / 1ps

// Mask IoU and mean depth error accumulator. Pixel requests of one particle's
// tile stream in at one per cycle while it accumulates; the tile ends with
// last_pixel set. The result for that tile (1 - I/U in Q1.16, mean absolute
// depth error with 8 fraction bits, and the raw counts) follows the last
// pixel; until it is loaded, no pixel is taken: a single shared 36-step
// restoring divider computes the IoU cost and then the mean depth error. The
// result sits in an output register, so the next tile can accumulate while it
// waits to be taken; a second tile end stalls only if that register is still
// full. Counts saturate at 131071, the error sum at 2^36 - 1.
module mask_iou_depth_error_accumulator import mide_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    mide_pix_if.sink    pix,
    mide_res_if.source  res
);

    mide_cmd_t  cmd;
    mide_stat_t stat;

    mide_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix.valid),
        .pix_last  (pix.last_pixel),
        .res_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (pix.ready),
        .out_valid (res.valid)
    );

    mide_datapath u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .meas_mask          (pix.meas_mask),
        .rend_mask          (pix.rend_mask),
        .meas_depth         (pix.meas_depth),
        .rend_depth         (pix.rend_depth),
        .cmd                (cmd),
        .stat               (stat),
        .iou_cost           (res.iou_cost),
        .mean_depth_error   (res.mean_depth_error),
        .intersection_count (res.intersection_count),
        .union_count        (res.union_count),
        .depth_pixel_count  (res.depth_pixel_count),
        .depth_error_sum    (res.depth_error_sum),
        .union_empty        (res.union_empty)
    );

endmodule

// ===== rtl/mide_div.sv =====
`timescale 1ns / 1ps
`include "mask_iou_depth_error_accumulator_defines.svh"

// Restoring divider, one quotient bit per cycle.
module mide_div import mide_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CNT_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output logic             busy,
    output logic             done
);

    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [SUM_W-1:0]     quo_reg, quo_next;
    logic [CNT_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    logic [CNT_W:0]       shifted;
    logic [CNT_W:0]       trial;
    logic                 fits;

    // One shift-subtract step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[SUM_W-1]};
        trial   = shifted - {1'b0, dvs_reg};
        fits    = (shifted >= {1'b0, dvs_reg});
    end

    // Step sequencing
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
            quo_next = {quo_reg[SUM_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            dvs_reg <= divisor;
        end
    end

    assign quotient = quo_reg;
    assign busy     = busy_reg;
    assign done     = done_reg;

    `MIDE_ASSERT_NOW(a_done_follows_busy, done_reg, $past(busy_reg), "done without a running division")
    `MIDE_ASSERT_NEXT(a_last_step_done, busy_reg && !start && cnt_reg == DIV_CNT_W'(1), done_reg && !busy_reg, "final step did not finish")

endmodule

// ===== rtl/mide_datapath.sv =====
`timescale 1ns / 1ps

module mide_datapath import mide_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MASK_W-1:0]     meas_mask,
    input  logic [MASK_W-1:0]     rend_mask,
    input  logic [DEPTH_BITS-1:0] meas_depth,
    input  logic [DEPTH_BITS-1:0] rend_depth,
    input  mide_cmd_t             cmd,
    output mide_stat_t            stat,
    output logic [COST_W-1:0]     iou_cost,
    output logic [MEAN_W-1:0]     mean_depth_error,
    output logic [CNT_W-1:0]      intersection_count,
    output logic [CNT_W-1:0]      union_count,
    output logic [CNT_W-1:0]      depth_pixel_count,
    output logic [SUM_W-1:0]      depth_error_sum,
    output logic                  union_empty
);

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Accumulators
    logic [CNT_W-1:0] inter_reg, inter_next;
    logic [CNT_W-1:0] union_reg, union_next;
    logic [CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [SUM_W-1:0] dsum_reg, dsum_next;

    // Captured cost quotient and output register
    logic [COST_W-1:0] cost_q_reg;
    logic [COST_W-1:0] iou_cost_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [CNT_W-1:0]  inter_out_reg;
    logic [CNT_W-1:0]  union_out_reg;
    logic [CNT_W-1:0]  dcnt_out_reg;
    logic [SUM_W-1:0]  dsum_out_reg;
    logic              empty_reg;

    // Pixel decode
    logic                  mm, rm;
    logic [DEPTH_BITS-1:0] md, rd, dd;
    logic                  hit;
    logic [SUM_W:0]        sum_ext;

    // Divider hookup
    logic [CNT_W-1:0]  inter_clip;
    logic [CNT_W-1:0]  u_minus_i;
    logic [SUM_W-1:0]  div_dividend;
    logic [CNT_W-1:0]  div_divisor;
    logic [SUM_W-1:0]  div_quo;
    logic              div_busy;
    logic              div_done;

    // Masking, background removal, absolute difference
    always_comb
    begin
        mm      = |meas_mask;
        rm      = |rend_mask;
        md      = mm ? meas_depth : '0;
        rd      = (rend_depth == BG_DEPTH) ? '0 : rend_depth;
        hit     = (md != '0) && (rd != '0) && (md != rd);
        dd      = (md > rd) ? md - rd : rd - md;
        sum_ext = {1'b0, dsum_reg} + (SUM_W + 1)'(dd);
    end

    // Accumulator update; cleared when the result is loaded
    always_comb
    begin
        inter_next = inter_reg;
        union_next = union_reg;
        dcnt_next  = dcnt_reg;
        dsum_next  = dsum_reg;
        if (cmd.load)
        begin
            inter_next = '0;
            union_next = '0;
            dcnt_next  = '0;
            dsum_next  = '0;
        end
        else if (cmd.acc_en)
        begin
            if (mm && rm)
            begin
                inter_next = sat_inc(inter_reg);
            end
            if (mm || rm)
            begin
                union_next = sat_inc(union_reg);
            end
            if (hit)
            begin
                dcnt_next = sat_inc(dcnt_reg);
                dsum_next = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inter_reg <= '0;
            union_reg <= '0;
            dcnt_reg  <= '0;
            dsum_reg  <= '0;
        end
        else
        begin
            inter_reg <= inter_next;
            union_reg <= union_next;
            dcnt_reg  <= dcnt_next;
            dsum_reg  <= dsum_next;
        end
    end

    // Division operands: (U - I) << 16 / U, or sum / count
    always_comb
    begin
        inter_clip   = (inter_reg > union_reg) ? union_reg : inter_reg;
        u_minus_i    = union_reg - inter_clip;
        div_dividend = cmd.div_mean ? dsum_reg
                                    : SUM_W'({u_minus_i, {FRAC_Q16{1'b0}}});
        div_divisor  = cmd.div_mean ? dcnt_reg : union_reg;
    end

    mide_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .busy     (div_busy),
        .done     (div_done)
    );

    // Cost quotient never exceeds 1.0, so its low bits suffice
    always_ff @(posedge clk)
    begin
        if (cmd.cap_cost)
        begin
            cost_q_reg <= div_quo[COST_W-1:0];
        end
    end

    // Output register, special cases resolved here
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            iou_cost_reg  <= (union_reg == '0) ? ONE_Q16 : cost_q_reg;
            empty_reg     <= (union_reg == '0);
            if (dcnt_reg == '0)
            begin
                mean_reg <= ONE_Q8;
            end
            else
            begin
                mean_reg <= (|div_quo[SUM_W-1:MEAN_W]) ? MEAN_MAX : div_quo[MEAN_W-1:0];
            end
            inter_out_reg <= inter_reg;
            union_out_reg <= union_reg;
            dcnt_out_reg  <= dcnt_reg;
            dsum_out_reg  <= dsum_reg;
        end
    end

    assign stat.div_busy      = div_busy;
    assign stat.div_done      = div_done;
    assign iou_cost           = iou_cost_reg;
    assign mean_depth_error   = mean_reg;
    assign intersection_count = inter_out_reg;
    assign union_count        = union_out_reg;
    assign depth_pixel_count  = dcnt_out_reg;
    assign depth_error_sum    = dsum_out_reg;
    assign union_empty        = empty_reg;

endmodule

// ===== rtl/mide_ctrl.sv =====
`timescale 1ns / 1ps
`include "mask_iou_depth_error_accumulator_defines.svh"

module mide_ctrl import mide_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pix_valid,
    input  logic       pix_last,
    input  logic       res_ready,
    input  mide_stat_t stat,
    output mide_cmd_t  cmd,
    output logic       in_ready,
    output logic       out_valid
);

    mide_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    assign out_free = !out_valid_reg || res_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:
            begin
                if (pix_valid && pix_last)
                begin
                    state_next = ST_COST_GO;
                end
            end
            ST_COST_GO:   state_next = ST_COST_WAIT;
            ST_COST_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_MEAN_GO;
                end
            end
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = ST_ACCUM;
                end
            end
            default:      state_next = ST_ACCUM;
        endcase
    end

    // Commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = pix_valid;
            end
            ST_COST_GO:   cmd.div_start = 1'b1;
            ST_COST_WAIT: cmd.cap_cost  = stat.div_done;
            ST_MEAN_GO:
            begin
                cmd.div_start = 1'b1;
                cmd.div_mean  = 1'b1;
            end
            ST_MEAN_WAIT: cmd.div_mean  = 1'b1;
            ST_LOAD:      cmd.load      = out_free;
            default:      cmd           = '0;
        endcase
    end

    // Output register occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `MIDE_ASSERT_NEXT(a_last_starts_div, cmd.acc_en && pix_last, state_reg == ST_COST_GO, "last pixel did not start the divisions")
    `MIDE_ASSERT_NOW(a_start_when_idle, cmd.div_start, !stat.div_busy, "division launched while divider busy")
    `MIDE_ASSERT_NOW(a_result_from_load, $rose(out_valid_reg), $past(cmd.load), "result shown without a load")

endmodule

// ===== tb/sv/mask_iou_depth_error_accumulator_tb.sv =====
`timescale 1ns / 1ps

module mask_iou_depth_error_accumulator_tb;
    import mide_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 12;
    localparam int RANDOM_PIXELS   = 1700;
    localparam int CALM_TAIL       = 250;     // last random pixels sent with no idling
    localparam int DRAIN_CYCLES    = 120;
    localparam int CYCLE_LIMIT     = 1_500_000;

    typedef struct {
        logic [MASK_W-1:0]     meas_mask;
        logic [MASK_W-1:0]     rend_mask;
        logic [DEPTH_BITS-1:0] meas_depth;
        logic [DEPTH_BITS-1:0] rend_depth;
        logic                  last_pixel;
    } pixel_t;

    typedef struct {
        logic [COST_W-1:0] cost;
        logic [MEAN_W-1:0] mean_err;
        logic [CNT_W-1:0]  inter_cnt;
        logic [CNT_W-1:0]  union_cnt;
        logic [CNT_W-1:0]  depth_cnt;
        logic [SUM_W-1:0]  err_sum;
        logic              empty_flag;
    } tile_result_t;

    // One line of the directed script; reps > 1 repeats the pixel, last only on the final copy
    typedef struct {
        pixel_t       px;
        int unsigned  reps;
        bit           typed;
        tile_result_t want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mide_pix_if pix ();
    mide_res_if res ();

    mask_iou_depth_error_accumulator uut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix),
        .res   (res)
    );

    // Tile accumulators of the predictor
    logic [CNT_W-1:0] tile_inter      = '0;
    logic [CNT_W-1:0] tile_union      = '0;
    logic [SUM_W-1:0] tile_err_sum    = '0;
    logic [CNT_W-1:0] tile_err_pixels = '0;

    tile_result_t tile_results_due[$];
    tile_result_t no_result = '{default: '0};
    int unsigned  mismatches  = 0;
    int unsigned  cycle_count = 0;
    int unsigned  stall_left  = 0;
    bit           idle_on     = 1'b1;

    always #HALF_PERIOD clk = ~clk;

    // Hard stop
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("mask_iou_depth_error_accumulator_tb failed");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] sat_bump(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    // Fold one pixel into the tile; on the last pixel return 1 with the tile result
    function automatic bit fold_pixel(input pixel_t p, output tile_result_t r);
        logic [DEPTH_BITS-1:0] md;
        logic [DEPTH_BITS-1:0] rd;
        logic [DEPTH_BITS-1:0] diff;
        logic [SUM_W:0]        wide_sum;
        longint unsigned       u;
        longint unsigned       i;
        longint unsigned       m;
        bit                    mm;
        bit                    rm;

        r  = no_result;
        mm = (p.meas_mask != '0);
        rm = (p.rend_mask != '0);
        md = mm ? p.meas_depth : '0;
        rd = (p.rend_depth == BG_DEPTH) ? '0 : p.rend_depth;

        if (md != '0 && rd != '0 && md != rd)
        begin
            diff         = (md > rd) ? md - rd : rd - md;
            wide_sum     = {1'b0, tile_err_sum} + diff;
            tile_err_sum = wide_sum[SUM_W] ? SUM_MAX : wide_sum[SUM_W-1:0];
            tile_err_pixels = sat_bump(tile_err_pixels);
        end
        if (mm && rm)
            tile_inter = sat_bump(tile_inter);
        if (mm || rm)
            tile_union = sat_bump(tile_union);

        if (!p.last_pixel)
            return 1'b0;

        // IoU cost, forced to one on an empty union
        if (tile_union == '0)
        begin
            r.cost       = ONE_Q16;
            r.empty_flag = 1'b1;
        end
        else
        begin
            u = tile_union;
            i = (tile_inter > tile_union) ? tile_union : tile_inter;
            r.cost = COST_W'(((u - i) << FRAC_Q16) / u);
        end

        // Mean depth error, one when no depth pixel counted
        if (tile_err_pixels == '0)
            r.mean_err = ONE_Q8;
        else
        begin
            m = tile_err_sum / tile_err_pixels;
            r.mean_err = (m > MEAN_MAX) ? MEAN_MAX : MEAN_W'(m);
        end

        r.inter_cnt = tile_inter;
        r.union_cnt = tile_union;
        r.depth_cnt = tile_err_pixels;
        r.err_sum   = tile_err_sum;

        tile_inter      = '0;
        tile_union      = '0;
        tile_err_sum    = '0;
        tile_err_pixels = '0;
        return 1'b1;
    endfunction

    function automatic tile_result_t tile_res(input longint unsigned cost, mean_err, inter_cnt,
                                              union_cnt, depth_cnt, err_sum, empty_flag);
        tile_result_t r;
        r.cost       = COST_W'(cost);
        r.mean_err   = MEAN_W'(mean_err);
        r.inter_cnt  = CNT_W'(inter_cnt);
        r.union_cnt  = CNT_W'(union_cnt);
        r.depth_cnt  = CNT_W'(depth_cnt);
        r.err_sum    = SUM_W'(err_sum);
        r.empty_flag = empty_flag[0];
        return r;
    endfunction

    function automatic stim_row_t stim_row(input logic [MASK_W-1:0] mm, rm,
                                           input logic [DEPTH_BITS-1:0] md, rd,
                                           input logic last, input int unsigned reps);
        stim_row_t s;
        s.px    = '{meas_mask: mm, rend_mask: rm, meas_depth: md, rend_depth: rd,
                    last_pixel: last};
        s.reps  = reps;
        s.typed = 1'b0;
        s.want  = no_result;
        return s;
    endfunction

    // Single-pixel tile with a hand-derived result
    function automatic stim_row_t known_row(input logic [MASK_W-1:0] mm, rm,
                                            input logic [DEPTH_BITS-1:0] md, rd,
                                            input tile_result_t want);
        stim_row_t s;
        s       = stim_row(mm, rm, md, rd, 1'b1, 1);
        s.typed = 1'b1;
        s.want  = want;
        return s;
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return MASK_W'(1) << $urandom_range(0, MASK_W - 1);
            default: return MASK_W'($urandom);
        endcase
    endfunction

    function automatic pixel_t pick_pixel(input bit blank);
        pixel_t p;
        p.meas_mask = blank ? '0 : pick_mask();
        p.rend_mask = blank ? '0 : pick_mask();
        case ($urandom_range(0, 5))
            0:       p.rend_depth = '0;
            1:       p.rend_depth = BG_DEPTH;
            2:       p.rend_depth = BG_DEPTH + DEPTH_BITS'($urandom_range(0, 2)) - 1'b1;
            3:       p.rend_depth = '1;
            default: p.rend_depth = DEPTH_BITS'($urandom);
        endcase
        // Measured depth often sits on or near the rendered one
        case ($urandom_range(0, 6))
            0:       p.meas_depth = '0;
            1:       p.meas_depth = p.rend_depth;
            2:       p.meas_depth = p.rend_depth + DEPTH_BITS'($urandom_range(0, 64))
                                    - DEPTH_BITS'(32);
            3:       p.meas_depth = '1;
            4:       p.meas_depth = BG_DEPTH;
            default: p.meas_depth = DEPTH_BITS'($urandom);
        endcase
        p.last_pixel = 1'b0;
        return p;
    endfunction

    // Drive one pixel request, optionally after an idle burst, and log its expectation
    task automatic send_pixel(input pixel_t p, input bit may_idle, input bit typed,
                              input tile_result_t want);
        tile_result_t r;
        @(negedge clk);
        if (may_idle && idle_on && $urandom_range(0, 9) == 0)
        begin
            pix.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        pix.valid      <= 1'b1;
        pix.meas_mask  <= p.meas_mask;
        pix.rend_mask  <= p.rend_mask;
        pix.meas_depth <= p.meas_depth;
        pix.rend_depth <= p.rend_depth;
        pix.last_pixel <= p.last_pixel;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        if (fold_pixel(p, r))
            tile_results_due.push_back(typed ? want : r);
    endtask

    // Result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (idle_on && stall_left == 0 && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0)
        begin
            res.ready <= 1'b0;
            stall_left--;
        end
        else
            res.ready <= 1'b1;
    end

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        tile_result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (tile_results_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result, expected none got cost %0d union %0d",
                         $time, res.iou_cost, res.union_count);
            end
            else
            begin
                want = tile_results_due.pop_front();
                check_field("iou_cost", want.cost, res.iou_cost);
                check_field("mean_depth_error", want.mean_err, res.mean_depth_error);
                check_field("intersection_count", want.inter_cnt, res.intersection_count);
                check_field("union_count", want.union_cnt, res.union_count);
                check_field("depth_pixel_count", want.depth_cnt, res.depth_pixel_count);
                check_field("depth_error_sum", want.err_sum, res.depth_error_sum);
                check_field("union_empty", want.empty_flag, res.union_empty);
            end
        end
    end

    initial
    begin
        stim_row_t   script[$];
        pixel_t      p;
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        bit          blank;

        pix.valid      = 1'b0;
        pix.meas_mask  = '0;
        pix.rend_mask  = '0;
        pix.meas_depth = '0;
        pix.rend_depth = '0;
        pix.last_pixel = 1'b0;
        res.ready      = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty union right after reset
        script.push_back(known_row('0, '0, '0, '0,
                                   tile_res(ONE_Q16, ONE_Q8, 0, 0, 0, 0, 1)));
        script.push_back(known_row('1, '1, 20'h00100, 20'h00300,
                                   tile_res(0, 'h200, 1, 1, 1, 'h200, 0)));
        // Background rendered depth counts as no depth
        script.push_back(known_row(8'h01, '0, 20'h00001, BG_DEPTH,
                                   tile_res(ONE_Q16, ONE_Q8, 0, 1, 0, 0, 0)));
        // Disjoint mask bit patterns still intersect; equal depths add nothing
        script.push_back(known_row(8'h0F, 8'hF0, 20'h00500, 20'h00500,
                                   tile_res(0, ONE_Q8, 1, 1, 0, 0, 0)));
        // Measured depth ignored outside the measured mask
        script.push_back(known_row('0, 8'h80, '1, 20'h00400,
                                   tile_res(ONE_Q16, ONE_Q8, 0, 1, 0, 0, 0)));
        script.push_back(known_row('1, '1, '1, 20'h00001,
                                   tile_res(0, 'hFFFFE, 1, 1, 1, 'hFFFFE, 0)));
        script.push_back(stim_row('1, 8'h01, 20'h00001, '1, 1'b1, 1));
        // Mixed tile around the background value
        script.push_back(stim_row(8'h80, '0, 20'h12345, 20'h23456, 1'b0, 1));
        script.push_back(stim_row('0, 8'h01, '0, 20'h00100, 1'b0, 1));
        script.push_back(stim_row(8'hAA, 8'h55, BG_DEPTH - 1'b1, BG_DEPTH + 1'b1, 1'b0, 1));
        script.push_back(stim_row(8'h55, 8'hAA, 20'h00100, BG_DEPTH, 1'b1, 1));
        // Cost of two thirds, truncated
        script.push_back(stim_row('1, '1, 20'h00200, 20'h00201, 1'b0, 1));
        script.push_back(stim_row('1, '0, 20'h00200, 20'h00202, 1'b0, 1));
        script.push_back(stim_row('0, '1, 20'h00200, 20'h00203, 1'b1, 1));
        // Mean truncation: sum 3 over 2 pixels
        script.push_back(stim_row(8'h40, 8'h02, 20'h01000, 20'h01001, 1'b0, 1));
        script.push_back(stim_row(8'h02, 8'h40, 20'h01002, 20'h01000, 1'b1, 1));
        // Accumulators start clean after the previous tile
        script.push_back(known_row('1, '1, 20'h00200, 20'h00100,
                                   tile_res(0, 'h100, 1, 1, 1, 'h100, 0)));

        foreach (script[k])
        begin
            for (int unsigned n = 1; n <= script[k].reps; n++)
            begin
                p = script[k].px;
                p.last_pixel = script[k].px.last_pixel && (n == script[k].reps);
                send_pixel(p, script[k].reps == 1, script[k].typed, script[k].want);
            end
        end

        // Random tiles, mostly short, a few long, some with an empty union
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                len = $urandom_range(1, 12);
            else if (pick < 97)
                len = $urandom_range(13, 64);
            else
                len = $urandom_range(65, 400);
            blank = ($urandom_range(0, 9) == 0);
            for (int unsigned n = 1; n <= len; n++)
            begin
                if (sent >= RANDOM_PIXELS - CALM_TAIL)
                    idle_on = 1'b0;
                p = pick_pixel(blank);
                p.last_pixel = (n == len);
                send_pixel(p, 1'b1, 1'b0, no_result);
                sent++;
            end
        end

        @(negedge clk);
        pix.valid <= 1'b0;

        while (tile_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("mask_iou_depth_error_accumulator_tb passed");
        else
            $display("mask_iou_depth_error_accumulator_tb failed");
        $finish;
    end

endmodule

// ===== mask_iou_depth_error_accumulator.f =====
+incdir+rtl
rtl/mide_pkg.sv
rtl/mide_pix_if.sv
rtl/mide_res_if.sv
rtl/mide_div.sv
rtl/mide_datapath.sv
rtl/mide_ctrl.sv
rtl/mask_iou_depth_error_accumulator.sv
tb/sv/mask_iou_depth_error_accumulator_tb.sv
